// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LFR_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define LFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- hdl/lfr_pkg.sv -----
// ----------------------------------------------------------------------------
// lfr_pkg
// Codes, field widths and default sizes of the fragment reassembler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfr_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned OFFS_W   = 10;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned EVT_W    = 2;
  localparam int unsigned MLEN_W   = 13;
  localparam int unsigned HDR_W    = 16;

  localparam int unsigned MSG_BYTES_DEF    = 4096;
  localparam int unsigned FRAG_PAYLOAD_DEF = 512;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE      = 2'd0,
    ACT_RELEASE    = 2'd1,
    ACT_DISCONNECT = 2'd2,
    ACT_READ       = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_BUSY    = 3'd1,
    ST_OFFSET  = 3'd2,
    ST_LENGTH  = 3'd3,
    ST_PREPARE = 3'd4,
    ST_NONE    = 3'd5
  } status_e;

  typedef enum logic [EVT_W-1:0] {
    EV_NONE     = 2'd0,
    EV_KICK     = 2'd1,
    EV_RESPONSE = 2'd2,
    EV_OVERFLOW = 2'd3
  } msg_event_e;

  // Result fields known at acceptance; the read byte joins them at the output register.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [EVT_W-1:0]  evt;
    logic [MLEN_W-1:0] mlen;
    logic              busy;
    logic              rd_ok;
  } res_t;

endpackage

// ----- hdl/lfr_in_if.sv -----
// ----------------------------------------------------------------------------
// lfr_in_if
// Input channel: one byte-level action per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfr_in_if;
  import lfr_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [DATA_W-1:0]   data_byte;
  logic                write_first;
  logic [OFFS_W-1:0]   write_offset;
  logic [OFFS_W-1:0]   write_length;
  logic                prepare_write;
  logic [IDX_W-1:0]    message_index;

  modport source (
    output valid, action, data_byte, write_first, write_offset, write_length,
           prepare_write, message_index,
    input  ready
  );

  modport sink (
    input  valid, action, data_byte, write_first, write_offset, write_length,
           prepare_write, message_index,
    output ready
  );
endinterface

// ----- hdl/lfr_out_if.sv -----
// ----------------------------------------------------------------------------
// lfr_out_if
// Output channel: one result per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lfr_out_if;
  import lfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] write_status;
  logic [EVT_W-1:0]  message_event;
  logic [MLEN_W-1:0] message_length;
  logic [DATA_W-1:0] read_byte;
  logic              busy_flag;

  modport source (
    output valid, write_status, message_event, message_length, read_byte, busy_flag,
    input  ready
  );

  modport sink (
    input  valid, write_status, message_event, message_length, read_byte, busy_flag,
    output ready
  );
endinterface

// ----- hdl/length_prefixed_fragment_reassembler.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed fragment reassembler
// Pipeline: store read stage, then output register. The store is one write and
// one read port. Throughput: one transaction per cycle while out_o is not stalled.
// Reset: control state cleared asynchronously; the store is not cleared, bytes at
// or above the message count are never returned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_fragment_reassembler #(
  parameter int unsigned MSG_BYTES    = lfr_pkg::MSG_BYTES_DEF,
  parameter int unsigned FRAG_PAYLOAD = lfr_pkg::FRAG_PAYLOAD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lfr_in_if.sink     in_i,
  lfr_out_if.source  out_o
);
  import lfr_pkg::*;

  // Sizes derived from the parameters.
  localparam int unsigned CW = $clog2(MSG_BYTES + 1);     // message count
  localparam int unsigned AW = $clog2(MSG_BYTES);         // store address
  localparam int unsigned XW = ((CW > IDX_W) ? CW : IDX_W) + 1;  // address maths
  localparam int unsigned SW = ((CW > HDR_W) ? CW : HDR_W) + 1;  // count + header
  localparam int unsigned FRAG_LIMIT = 2 + FRAG_PAYLOAD;

  // --------------------------------------------------------------------------
  // Reassembly state (registers) and the message store (memory)
  // --------------------------------------------------------------------------
  logic [CW-1:0]     cnt_q, cnt_d;       // bytes held in the store
  logic              ovf_q, ovf_d;       // a fragment did not fit
  logic              pend_q, pend_d;     // completed message awaits release
  logic [OFFS_W-1:0] fc_q, fc_d;         // bytes of the current fragment so far
  logic [HDR_W-1:0]  hdr_q, hdr_d;       // fragment length prefix
  logic [OFFS_W-1:0] rem_q, rem_d;       // bytes left in the current write
  logic [STAT_W-1:0] ver_q, ver_d;       // verdict governing the current write

  logic [DATA_W-1:0] store_q [MSG_BYTES];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;

  // Handshake and pipeline
  logic              in_acc;
  logic              s1_v_q, s1_adv;
  res_t              s1_q, res;
  logic              out_v_q;
  res_t              out_q;
  logic [DATA_W-1:0] out_byte_q;

  // Per-transaction working values
  logic [OFFS_W-1:0] len_n;      // write length, zero taken as one
  logic [OFFS_W-1:0] fc_cur;     // fragment position after a zero-offset restart
  logic [STAT_W-1:0] ver_new;
  logic [OFFS_W-1:0] rem_cur;
  logic [STAT_W-1:0] ver_cur;
  logic [OFFS_W-1:0] fc_inc;
  logic [HDR_W-1:0]  hdr_nx;
  logic [XW-1:0]     wat, idx_x;
  logic [SW-1:0]     cnt_sum;

  assign in_acc = in_i.valid && in_i.ready;

  // --------------------------------------------------------------------------
  // First-byte checks: prepare, then busy, then offset, then length.
  // A zero offset restarts the fragment even if the length check fails.
  // --------------------------------------------------------------------------
  always_comb begin
    len_n = (in_i.write_length == '0) ? OFFS_W'(1) : in_i.write_length;
    if (in_i.write_first && !in_i.prepare_write && !pend_q && in_i.write_offset == '0) begin
      fc_cur = '0;
    end else begin
      fc_cur = fc_q;
    end

    if (in_i.prepare_write) begin
      ver_new = ST_PREPARE;
    end else if (pend_q) begin
      ver_new = ST_BUSY;
    end else if (in_i.write_offset != '0 && in_i.write_offset != fc_q) begin
      ver_new = ST_OFFSET;
    end else if ((11'(fc_cur) + 11'(len_n)) > 11'(FRAG_LIMIT)) begin
      ver_new = ST_LENGTH;
    end else begin
      ver_new = ST_OK;
    end

    rem_cur = in_i.write_first ? len_n   : rem_q;
    ver_cur = in_i.write_first ? ver_new : ver_q;
  end

  // Byte placement within the fragment: two header bytes, then payload.
  always_comb begin
    hdr_nx = hdr_q;
    if (fc_cur == '0) begin
      hdr_nx = {in_i.data_byte, hdr_q[7:0]};
    end else if (fc_cur == OFFS_W'(1)) begin
      hdr_nx = {hdr_q[15:8], in_i.data_byte};
    end
    fc_inc  = (11'(fc_cur) < 11'(FRAG_LIMIT)) ? fc_cur + OFFS_W'(1) : fc_cur;
    wat     = XW'(cnt_q) + XW'(fc_cur) - XW'(2);
    idx_x   = XW'(in_i.message_index);
    cnt_sum = SW'(cnt_q) + SW'(hdr_nx);
  end

  // --------------------------------------------------------------------------
  // State update for the accepted transaction
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    pend_d     = pend_q;
    fc_d       = fc_q;
    hdr_d      = hdr_q;
    rem_d      = rem_q;
    ver_d      = ver_q;
    res.status = ST_NONE;
    res.evt    = EV_NONE;
    res.rd_ok  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = wat[AW-1:0];
    mem_raddr  = idx_x[AW-1:0];

    case (in_i.action)
      ACT_WRITE: begin
        if (in_i.write_first) begin
          rem_d = len_n;
          ver_d = ver_new;
          fc_d  = fc_cur;
        end
        if (rem_cur != '0) begin
          res.status = ver_cur;
          rem_d      = rem_cur - OFFS_W'(1);
          if (ver_cur == ST_OK) begin
            hdr_d  = hdr_nx;
            fc_d   = fc_inc;
            mem_we = (fc_cur >= OFFS_W'(2)) && (wat < XW'(MSG_BYTES));
            // Fragment completes when the write ends with the prefix satisfied.
            if (rem_cur == OFFS_W'(1) && fc_inc >= OFFS_W'(2) &&
                17'(fc_inc) >= (17'(hdr_nx) + 17'd2)) begin
              fc_d = '0;
              if (hdr_nx == '0) begin
                // Empty fragment closes the message.
                pend_d = 1'b1;
                if (cnt_q == '0) begin
                  res.evt = EV_KICK;
                end else if (ovf_q) begin
                  res.evt = EV_OVERFLOW;
                end else begin
                  res.evt = EV_RESPONSE;
                end
              end else if (cnt_sum > SW'(MSG_BYTES)) begin
                ovf_d = 1'b1;
              end else begin
                cnt_d = CW'(cnt_sum);
              end
            end
          end
        end
      end
      ACT_RELEASE: begin
        cnt_d  = '0;
        ovf_d  = 1'b0;
        fc_d   = '0;
        pend_d = 1'b0;
        rem_d  = '0;
      end
      ACT_DISCONNECT: begin
        if (!pend_q) begin
          cnt_d = '0;
          ovf_d = 1'b0;
          fc_d  = '0;
        end
        rem_d = '0;
      end
      ACT_READ: begin
        res.rd_ok = (idx_x < XW'(cnt_q)) && (idx_x < XW'(MSG_BYTES));
        mem_re    = res.rd_ok;
      end
      default: begin
      end
    endcase

    res.mlen = MLEN_W'(cnt_d);
    res.busy = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      pend_q <= 1'b0;
      fc_q   <= '0;
      hdr_q  <= '0;
      rem_q  <= '0;
      ver_q  <= ST_OK;
    end else if (in_acc) begin
      cnt_q  <= cnt_d;
      ovf_q  <= ovf_d;
      pend_q <= pend_d;
      fc_q   <= fc_d;
      hdr_q  <= hdr_d;
      rem_q  <= rem_d;
      ver_q  <= ver_d;
    end
  end

  // Message store: one write and one registered read per cycle. A byte written
  // by one transaction is visible to a read in the next, so no forwarding.
  always_ff @(posedge clk_i) begin
    if (in_acc && mem_we) begin
      store_q[mem_waddr] <= in_i.data_byte;
    end
    if (in_acc && mem_re) begin
      rdata_q <= store_q[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Result pipeline: stage 1 waits for the store read, then the output register.
  // Stage 1 only advances when the output is free, so rdata_q holds meanwhile.
  // --------------------------------------------------------------------------
  assign s1_adv     = s1_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !s1_v_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= res;
    end
    if (s1_adv) begin
      out_q      <= s1_q;
      out_byte_q <= s1_q.rd_ok ? rdata_q : '0;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.write_status   = out_q.status;
  assign out_o.message_event  = out_q.evt;
  assign out_o.message_length = out_q.mlen;
  assign out_o.read_byte      = out_byte_q;
  assign out_o.busy_flag      = out_q.busy;

endmodule

// ----- hdl/lfr_checker.sv -----
// ----------------------------------------------------------------------------
// lfr_checker
// Port-level checks on the reassembler result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [lfr_pkg::STAT_W-1:0] write_status_i,
  input logic [lfr_pkg::EVT_W-1:0]  message_event_i,
  input logic [lfr_pkg::DATA_W-1:0] read_byte_i,
  input logic                      busy_flag_i
);
  import lfr_pkg::*;

  // A stalled result stays offered.
  `LFR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // Any message event closes the message, so busy is reported with it.
  `LFR_ASSERT(a_evt_busy, clk_i, rst_ni, out_valid_i && message_event_i != EV_NONE,
              busy_flag_i)

  // Rejected or foreign transactions never complete a fragment.
  `LFR_ASSERT(a_evt_ok, clk_i, rst_ni, out_valid_i && write_status_i != ST_OK,
              message_event_i == EV_NONE)

  // Only reads return data.
  `LFR_ASSERT(a_rd_only, clk_i, rst_ni, out_valid_i && read_byte_i != '0,
              write_status_i == ST_NONE && message_event_i == EV_NONE)

  // A busy drop can only be seen while busy.
  `LFR_ASSERT(a_busy_drop, clk_i, rst_ni, out_valid_i && write_status_i == ST_BUSY,
              busy_flag_i)

endmodule

bind length_prefixed_fragment_reassembler lfr_checker u_lfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .write_status_i  (out_o.write_status),
  .message_event_i (out_o.message_event),
  .read_byte_i     (out_o.read_byte),
  .busy_flag_i     (out_o.busy_flag)
);

// ----- tb/length_prefixed_fragment_reassembler_tb.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_fragment_reassembler_tb
// Self-checking bench for the fragment reassembler. A queue of byte-level
// transactions feeds a clocked driver. A behavioural copy of the reassembly
// state predicts one result per accepted transaction. A clocked monitor
// checks each returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_fragment_reassembler_tb;
  import lfr_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned TIMEOUT_CYCLES = 500000;
  localparam int unsigned TAIL_CYCLES    = 10;
  localparam int unsigned RAND_ITEMS     = 950;
  localparam int unsigned LONG_HOLD      = 150;
  localparam int unsigned STORE_BYTES    = MSG_BYTES_DEF;
  localparam int unsigned FRAG_LIMIT     = 2 + FRAG_PAYLOAD_DEF;

  typedef logic [DATA_W-1:0] byte_q_t[$];

  // One input transaction plus the sender's pacing for it.
  typedef struct packed {
    action_e            act;
    logic [DATA_W-1:0]  data;
    logic               first;
    logic [OFFS_W-1:0]  offs;
    logic [OFFS_W-1:0]  len;
    logic               prep;
    logic [IDX_W-1:0]   idx;
    logic [2:0]         gap;    // idle cycles before it is offered
    logic               drain;  // wait for every outstanding result first
  } reasm_txn_t;

  typedef struct packed {
    status_e            status;
    msg_event_e         evt;
    logic [MLEN_W-1:0]  mlen;
    logic [DATA_W-1:0]  rbyte;
    logic               busy;
  } reasm_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  lfr_in_if  in_if ();
  lfr_out_if out_if ();

  // TB-side drive registers, known from time zero
  logic       drv_valid  = 1'b0;
  reasm_txn_t drv_txn    = '0;
  logic       sink_ready = 1'b0;

  assign in_if.valid         = drv_valid;
  assign in_if.action        = drv_txn.act;
  assign in_if.data_byte     = drv_txn.data;
  assign in_if.write_first   = drv_txn.first;
  assign in_if.write_offset  = drv_txn.offs;
  assign in_if.write_length  = drv_txn.len;
  assign in_if.prepare_write = drv_txn.prep;
  assign in_if.message_index = drv_txn.idx;
  assign out_if.ready        = sink_ready;

  length_prefixed_fragment_reassembler #(
    .MSG_BYTES    (MSG_BYTES_DEF),
    .FRAG_PAYLOAD (FRAG_PAYLOAD_DEF)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // --------------------------------------------------------------------------
  // Shadow of the reassembly state
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] sh_store [STORE_BYTES];
  int unsigned       sh_count;       // bytes held in the message store
  bit                sh_overflow;
  bit                sh_pending;     // completed message awaiting release
  int unsigned       sh_frag_bytes;  // bytes of the current fragment so far
  logic [HDR_W-1:0]  sh_header;      // length prefix of the current fragment
  int unsigned       sh_write_left;
  status_e           sh_verdict = ST_OK;

  reasm_txn_t    stim_q[$];
  reasm_result_t result_q[$];

  // Driver-private pacing state
  reasm_txn_t  next_txn;
  bit          staged;
  int unsigned gap_left;
  bit          quiet_gaps;  // generation-time: offer back to back

  int unsigned n_accepted = 0;
  int unsigned n_results;
  int unsigned mismatches;
  int unsigned status_seen [8];
  int unsigned event_seen [4];
  int unsigned peak_len;

  // Works out the result of one accepted transaction and advances the shadow.
  function automatic reasm_result_t reassemble(input reasm_txn_t t);
    reasm_result_t r;
    int unsigned   at;
    r.status = ST_NONE;
    r.evt    = EV_NONE;
    r.rbyte  = '0;
    case (t.act)
      ACT_WRITE: begin
        if (t.first) begin
          // a zero length counts as one byte; a first byte abandons any old write
          sh_write_left = (t.len == 0) ? 1 : t.len;
          if (t.prep) begin
            sh_verdict = ST_PREPARE;
          end else if (sh_pending) begin
            sh_verdict = ST_BUSY;
          end else begin
            // offset zero restarts the fragment even if the length check fails
            if (t.offs == 0) sh_frag_bytes = 0;
            if (t.offs != 0 && t.offs != sh_frag_bytes) sh_verdict = ST_OFFSET;
            else if (sh_frag_bytes + sh_write_left > FRAG_LIMIT) sh_verdict = ST_LENGTH;
            else sh_verdict = ST_OK;
          end
        end
        // stray bytes with no write in progress fall through as ST_NONE
        if (sh_write_left != 0) begin
          r.status = sh_verdict;
          sh_write_left--;
          if (sh_verdict == ST_OK) begin
            if (sh_frag_bytes == 0) begin
              sh_header[15:8] = t.data;
            end else if (sh_frag_bytes == 1) begin
              sh_header[7:0] = t.data;
            end else begin
              // bytes beyond the store, or past the declared length, stay invisible
              at = sh_count + sh_frag_bytes - 2;
              if (at < STORE_BYTES) sh_store[at] = t.data;
            end
            if (sh_frag_bytes < FRAG_LIMIT) sh_frag_bytes++;
            if (sh_write_left == 0 && sh_frag_bytes >= 2 &&
                sh_frag_bytes >= 2 + sh_header) begin
              if (sh_header == 0) begin
                // empty fragment closes the message
                sh_pending = 1'b1;
                if (sh_count == 0) r.evt = EV_KICK;
                else if (sh_overflow) r.evt = EV_OVERFLOW;
                else r.evt = EV_RESPONSE;
              end else if (sh_count + sh_header > STORE_BYTES) begin
                sh_overflow = 1'b1;
              end else begin
                sh_count += sh_header;
              end
              sh_frag_bytes = 0;
            end
          end
        end
      end
      ACT_RELEASE: begin
        sh_count      = 0;
        sh_overflow   = 1'b0;
        sh_frag_bytes = 0;
        sh_pending    = 1'b0;
        sh_write_left = 0;
      end
      ACT_DISCONNECT: begin
        // a pending message survives a disconnect
        if (!sh_pending) begin
          sh_count      = 0;
          sh_overflow   = 1'b0;
          sh_frag_bytes = 0;
        end
        sh_write_left = 0;
      end
      default: begin
        if (t.idx < sh_count) r.rbyte = sh_store[t.idx];
      end
    endcase
    r.mlen = MLEN_W'(sh_count);
    r.busy = sh_pending;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic void add_item(action_e act, int unsigned data, int unsigned first,
                                   int unsigned offs, int unsigned len,
                                   int unsigned prep, int unsigned idx);
    reasm_txn_t t;
    t.act   = act;
    t.data  = DATA_W'(data);
    t.first = first[0];
    t.offs  = OFFS_W'(offs);
    t.len   = OFFS_W'(len);
    t.prep  = prep[0];
    t.idx   = IDX_W'(idx);
    t.gap   = quiet_gaps ? 3'd0 : 3'($urandom_range(0, 5));
    t.drain = 1'b0;
    stim_q.push_back(t);
  endfunction

  // Non-write actions carry random payload fields that the block must ignore.
  function automatic void add_op(action_e act, int unsigned idx);
    add_item(act, $urandom, $urandom_range(0, 1), $urandom, $urandom,
             $urandom_range(0, 1), idx);
  endfunction

  function automatic byte_q_t rand_bytes(int unsigned n);
    byte_q_t q;
    repeat (n) q.push_back(DATA_W'($urandom));
    return q;
  endfunction

  // One write: offset, length and prepare flag go with the first byte only.
  function automatic void add_write(int unsigned offs, int unsigned len,
                                    bit prep, byte_q_t wbytes);
    foreach (wbytes[i]) begin
      if (i == 0) add_item(ACT_WRITE, wbytes[i], 1'b1, offs, len, prep, $urandom);
      else add_item(ACT_WRITE, wbytes[i], 1'b0, $urandom, $urandom, $urandom_range(0, 1),
                    $urandom);
    end
  endfunction

  // Header plus plen payload bytes, split into up to `pieces` contiguous writes.
  function automatic void add_fragment(int unsigned plen, logic [HDR_W-1:0] hdr,
                                       int unsigned pieces);
    byte_q_t     frag_bytes;
    byte_q_t     chunk;
    int unsigned pos;
    int unsigned cnt;
    frag_bytes = rand_bytes(plen);
    frag_bytes.push_front(hdr[7:0]);
    frag_bytes.push_front(hdr[15:8]);
    pos = 0;
    for (int unsigned k = 0; k < pieces && pos < frag_bytes.size(); k++) begin
      cnt = (k == pieces - 1) ? frag_bytes.size() - pos
                              : $urandom_range(1, frag_bytes.size() - pos);
      chunk.delete();
      for (int unsigned j = 0; j < cnt; j++) chunk.push_back(frag_bytes[pos + j]);
      add_write(pos, (cnt == 1 && $urandom_range(0, 1)) ? 10'd0 : OFFS_W'(cnt), 1'b0, chunk);
      pos += cnt;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Driver: offers queued transactions, predicts each one as it is accepted
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit            offer;
    reasm_result_t r;
    if (rst_ni) begin
      offer = drv_valid;
      if (drv_valid && in_if.ready) begin
        r = reassemble(drv_txn);
        result_q.push_back(r);
        status_seen[r.status]++;
        event_seen[r.evt]++;
        if (r.mlen > peak_len) peak_len = r.mlen;
        n_accepted <= n_accepted + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (!staged && stim_q.size() != 0) begin
          next_txn = stim_q.pop_front();
          staged   = 1'b1;
          gap_left = next_txn.gap;
        end
        if (staged && gap_left != 0) begin
          gap_left--;
        end else if (staged && !(next_txn.drain && result_q.size() != 0)) begin
          drv_txn <= next_txn;
          staged = 1'b0;
          offer  = 1'b1;
        end
      end
      // valid gets exactly one update per edge
      drv_valid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks results, paces ready, and applies the long back-pressure
  // --------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned hold_idx;
  bit          sink_burst;
  int unsigned hold_points [2] = '{60, 600};

  function automatic void flag_mismatch(string field, int unsigned want_v,
                                        logic [15:0] got_v);
    $display("%0t ns: %s mismatch on result %0d: expected %0d, actual %0d",
             $time, field, n_results, want_v, got_v);
    mismatches++;
  endfunction

  always @(posedge clk_i) begin
    reasm_result_t want;
    if (rst_ni) begin
      if (out_if.valid && sink_ready) begin
        n_results++;
        if (result_q.size() == 0) begin
          $display("%0t ns: result %0d arrived with no transaction waiting (status %0d)",
                   $time, n_results, out_if.write_status);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (out_if.write_status !== want.status)
            flag_mismatch("write_status", want.status, out_if.write_status);
          if (out_if.message_event !== want.evt)
            flag_mismatch("message_event", want.evt, out_if.message_event);
          if (out_if.message_length !== want.mlen)
            flag_mismatch("message_length", want.mlen, out_if.message_length);
          if (out_if.read_byte !== want.rbyte)
            flag_mismatch("read_byte", want.rbyte, out_if.read_byte);
          if (out_if.busy_flag !== want.busy)
            flag_mismatch("busy_flag", want.busy, out_if.busy_flag);
        end
        stall_left = sink_burst ? 0 : $urandom_range(0, 5);
        // alternate between idling and back-to-back stretches
        if (n_results % 100 == 0) sink_burst = ($urandom_range(0, 3) == 0);
      end
      // long hold-off: the pipe fills and the input must stall
      if (hold_idx < 2 && n_accepted >= hold_points[hold_idx]) begin
        hold_left = LONG_HOLD;
        hold_idx++;
      end
      if (hold_left != 0) begin
        hold_left--;
        sink_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    byte_q_t     wb;
    int unsigned n_rand;
    int unsigned start;
    int unsigned plen;

    // shadow reset
    foreach (sh_store[i]) sh_store[i] = '0;
    sh_count      = 0;
    sh_overflow   = 1'b0;
    sh_pending    = 1'b0;
    sh_frag_bytes = 0;
    sh_header     = '0;
    sh_write_left = 0;
    quiet_gaps    = 1'b0;

    // -- directed part --
    add_op(ACT_READ, 12'd0);                                  // read of an empty store
    add_item(ACT_WRITE, 8'h5a, 1'b0, 10'h3ff, 10'h3ff, 1'b1, 12'hfff);  // stray byte
    add_op(ACT_RELEASE, 12'd0);
    add_op(ACT_DISCONNECT, 12'hfff);
    add_write(10'd0, 10'd1, 1'b1, '{8'hff});                  // prepare write ignored
    add_write(10'd0, 10'd5, 1'b0, '{8'h00, 8'h03, 8'hff, 8'h00, 8'ha5});  // 3-byte fragment
    add_write(10'h3ff, 10'd1, 1'b0, '{8'h11});                // offset out of sequence
    add_write(10'd0, 10'h3ff, 1'b0, '{8'h22, 8'h33});         // too long for a fragment
    add_write(10'd0, 10'd0, 1'b0, '{8'h00});                  // zero length, new write cuts old
    add_write(10'd1, 10'd0, 1'b0, '{8'h00});                  // empty fragment: response
    add_op(ACT_READ, 12'd0);
    add_op(ACT_READ, 12'd3);                                  // at the message length
    add_op(ACT_READ, 12'hfff);
    add_write(10'd0, 10'd2, 1'b0, '{8'h01, 8'h02});           // dropped while busy
    add_write(10'd0, 10'd1, 1'b1, '{8'h00});                  // prepare beats busy
    add_op(ACT_DISCONNECT, 12'd0);                            // pending message kept
    add_op(ACT_READ, 12'd2);
    add_op(ACT_RELEASE, 12'd0);
    add_write(10'd0, 10'd2, 1'b0, '{8'h00, 8'h00});           // kick on empty message
    add_op(ACT_RELEASE, 12'd0);

    // -- random part --
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      start      = stim_q.size();
      quiet_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 6) begin
        // well-formed message with random content
        if ($urandom_range(0, 1)) add_op(ACT_RELEASE, $urandom);
        repeat ($urandom_range(0, 3)) begin
          plen = ($urandom_range(0, 15) == 0) ? $urandom_range(100, FRAG_PAYLOAD_DEF)
                                              : $urandom_range(1, 24);
          if ($urandom_range(0, 9) == 0) begin
            wb = rand_bytes($urandom_range(1, 3));
            add_write($urandom, wb.size(), 1'b1, wb);
          end
          add_fragment(plen, HDR_W'(plen), $urandom_range(1, 3));
          if ($urandom_range(0, 5) == 0) add_op(ACT_READ, $urandom_range(0, 63));
        end
        add_fragment(0, 16'h0000, $urandom_range(1, 2));
        repeat ($urandom_range(1, 4))
          add_op(ACT_READ, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40));
        if ($urandom_range(0, 2) == 0) add_write(10'd0, 10'd2, 1'b0, rand_bytes(2));
        if ($urandom_range(0, 2) == 0) add_op(ACT_DISCONNECT, $urandom);
        add_op(ACT_RELEASE, $urandom);
      end else begin
        // noise and broken sequences
        case ($urandom_range(0, 6))
          0: repeat ($urandom_range(1, 4))
               add_item(action_e'(ACTION_W'($urandom_range(0, 3))), $urandom,
                        $urandom_range(0, 1),
                        $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom,
                        $urandom, ($urandom_range(0, 3) == 0), $urandom);
          1: begin
            wb = rand_bytes($urandom_range(1, 3));
            add_write($urandom_range(1, 1023), wb.size(), 1'b0, wb);
          end
          2: add_write(10'd0, $urandom_range(FRAG_LIMIT + 1, 1023), 1'b0,
                       rand_bytes($urandom_range(1, 3)));
          3: begin
            // write cut short, then abandoned by a disconnect or a fresh write
            add_write(10'd0, $urandom_range(5, 20), 1'b0, rand_bytes(2));
            if ($urandom_range(0, 1)) add_op(ACT_DISCONNECT, $urandom);
          end
          4: begin
            // bytes past the declared length in one write
            plen = $urandom_range(0, 8);
            add_fragment(plen + $urandom_range(1, 4), HDR_W'(plen), 1);
            add_op(ACT_READ, $urandom_range(0, 15));
            add_op(ACT_RELEASE, $urandom);
          end
          5: add_fragment($urandom_range(0, 10),
                          HDR_W'($urandom_range(FRAG_PAYLOAD_DEF + 1, 65535)),
                          $urandom_range(1, 2));
          default: begin
            repeat ($urandom_range(1, 3))
              add_item(ACT_WRITE, $urandom, 1'b0, $urandom, $urandom,
                       $urandom_range(0, 1), $urandom);
            add_op(ACT_DISCONNECT, $urandom);
          end
        endcase
      end
      // sender pauses until the block has drained: always once, then now and then
      if (n_rand == 0 || $urandom_range(0, 19) == 0) stim_q[start].drain = 1'b1;
      n_rand += stim_q.size() - start;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || staged || drv_valid || result_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d transactions: %0d accepted bytes, %0d busy drops,",
             n_accepted, status_seen[ST_OK], status_seen[ST_BUSY]);
    $display("  %0d offset, %0d length and %0d prepare rejects; messages closed:",
             status_seen[ST_OFFSET], status_seen[ST_LENGTH], status_seen[ST_PREPARE]);
    $display("  %0d kick, %0d response, %0d overflow; peak store fill %0d bytes",
             event_seen[EV_KICK], event_seen[EV_RESPONSE], event_seen[EV_OVERFLOW], peak_len);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timeout: %0d results still outstanding", result_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
